### sv/tlc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types and codes for the two-level cache hit/miss tracker.
// ----------------------------------------------------------------------------
package tlc_pkg;

   localparam int TAG_W     = 32;
   localparam int SET1_W    = 12;   // widest L1 set index the parameters allow
   localparam int SET2_W    = 16;   // widest L2 set index the parameters allow
   localparam int WAYCNT_W  = 5;    // holds a way count up to 31
   localparam int SHIFT_W   = 5;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 5;

   localparam logic [2:0] ST_NONE = 3'd0;
   localparam logic [2:0] ST_RH   = 3'd1;
   localparam logic [2:0] ST_RM   = 3'd2;
   localparam logic [2:0] ST_WH   = 3'd3;
   localparam logic [2:0] ST_WM   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_L1_OFF  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_L1_IDX  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_L1_WAYS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_L2_OFF  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_L2_IDX  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_L2_WAYS = 3'd5;

   typedef struct packed {
      logic        req_type;
      logic [31:0] address;
   } tlc_req_type;

   typedef struct packed {
      logic [2:0] l1_status;
      logic [2:0] l2_status;
   } tlc_rsp_type;

   typedef struct packed {
      logic [4:0] l1_offset_bits;
      logic [2:0] l1_index_bits;
      logic [2:0] l1_ways_used;
      logic [4:0] l2_offset_bits;
      logic [3:0] l2_index_bits;
      logic [3:0] l2_ways_used;
   } tlc_cfg_type;

   typedef struct packed {
      logic                is_write;
      logic [SET1_W-1:0]   set1;
      logic [TAG_W-1:0]    tag1;
      logic [WAYCNT_W-1:0] ways1;
      logic [SET2_W-1:0]   set2;
      logic [TAG_W-1:0]    tag2;
      logic [WAYCNT_W-1:0] ways2;
   } tlc_item_type;

endpackage
`default_nettype wire

### sv/tlc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlc_front
// Accept beats, split the address into set and tag for both levels.
// ----------------------------------------------------------------------------
module tlc_front import tlc_pkg::*; #(
   parameter int L1_SETS   = 64,
   parameter int L1_WAYS   = 4,
   parameter int L2_SETS   = 512,
   parameter int L2_WAYS   = 8,
   parameter int ADDR_BITS = 32
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  tlc_req_type       req_data,
   input  tlc_cfg_type       cfg,
   output logic              push_valid,
   input  wire               push_ready,
   output tlc_item_type      push_data
);

   localparam int MAXIDX1 = $clog2(L1_SETS + 1) - 1;
   localparam int MAXIDX2 = $clog2(L2_SETS + 1) - 1;
   localparam logic [31:0] AMASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                   32'((64'h1 << ADDR_BITS) - 64'h1);

   logic         vld_ff;
   tlc_item_type item_ff;
   tlc_item_type item_in;
   logic [31:0]  addr;
   logic [4:0]   idx1, idx2;
   logic [31:0]  set1_raw, set2_raw;
   logic [5:0]   sh1, sh2;
   logic [WAYCNT_W-1:0] w1, w2;

   always_comb begin
      addr = req_data.address & AMASK;
      idx1 = (32'(cfg.l1_index_bits) > MAXIDX1) ? 5'(MAXIDX1) : 5'(cfg.l1_index_bits);
      idx2 = (32'(cfg.l2_index_bits) > MAXIDX2) ? 5'(MAXIDX2) : 5'(cfg.l2_index_bits);
      set1_raw = (addr >> cfg.l1_offset_bits) & ((32'h1 << idx1) - 32'h1);
      set2_raw = (addr >> cfg.l2_offset_bits) & ((32'h1 << idx2) - 32'h1);
      sh1 = 6'(cfg.l1_offset_bits) + 6'(idx1);
      sh2 = 6'(cfg.l2_offset_bits) + 6'(idx2);
      w1 = WAYCNT_W'(cfg.l1_ways_used);
      if (w1 == '0) w1 = WAYCNT_W'(1);
      if (32'(w1) > L1_WAYS) w1 = WAYCNT_W'(L1_WAYS);
      w2 = WAYCNT_W'(cfg.l2_ways_used);
      if (w2 == '0) w2 = WAYCNT_W'(1);
      if (32'(w2) > L2_WAYS) w2 = WAYCNT_W'(L2_WAYS);
      item_in.is_write = req_data.req_type;
      item_in.set1     = set1_raw[SET1_W-1:0];
      item_in.tag1     = addr >> sh1;
      item_in.ways1    = w1;
      item_in.set2     = set2_raw[SET2_W-1:0];
      item_in.tag2     = addr >> sh2;
      item_in.ways2    = w2;
   end

   assign req_ready  = !vld_ff || push_ready;
   assign push_valid = vld_ff;
   assign push_data  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         vld_ff  <= 1'b1;
         item_ff <= item_in;
      end else if (push_ready) begin
         vld_ff <= 1'b0;
      end
   end

endmodule
`default_nettype wire

### sv/tlc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlc_queue
// Two-entry queue between the classifier and the tag sequencer.
// ----------------------------------------------------------------------------
module tlc_queue import tlc_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   input  wire          push_valid,
   output logic         push_ready,
   input  tlc_item_type push_data,
   output logic         pop_valid,
   input  wire          pop_ready,
   output tlc_item_type pop_data
);

   tlc_item_type slot_ff [2];
   logic         wr_ff, rd_ff;
   logic [1:0]   cnt_ff;
   logic         push, pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule
`default_nettype wire

### sv/tlc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlc_back
// Tag sequencer: read both set rows, update L1, insert/lookup L2, respond.
// ----------------------------------------------------------------------------
module tlc_back import tlc_pkg::*; #(
   parameter int L1_SETS = 64,
   parameter int L1_WAYS = 4,
   parameter int L2_SETS = 512,
   parameter int L2_WAYS = 8
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          pop_valid,
   output logic         pop_ready,
   input  tlc_item_type pop_data,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output tlc_rsp_type  rsp_data,
   output logic         clearing
);

   localparam int S1_W  = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
   localparam int S2_W  = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
   localparam int P1_W  = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
   localparam int P2_W  = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
   localparam int CLR_N = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
   localparam int CLR_W = (CLR_N > 1) ? $clog2(CLR_N) : 1;

   typedef enum logic [2:0] {S_CLR, S_IDLE, S_L1, S_L2, S_L2B} state_type;

   // set-row memories
   logic [L1_WAYS-1:0][TAG_W-1:0] l1_tag_mem [L1_SETS];
   logic [L1_WAYS-1:0]            l1_vld_mem [L1_SETS];
   logic [P1_W-1:0]               l1_ptr_mem [L1_SETS];
   logic [L2_WAYS-1:0][TAG_W-1:0] l2_tag_mem [L2_SETS];
   logic [L2_WAYS-1:0]            l2_vld_mem [L2_SETS];
   logic [P2_W-1:0]               l2_ptr_mem [L2_SETS];

   logic [L1_WAYS-1:0][TAG_W-1:0] l1_tag_rd_ff;
   logic [L1_WAYS-1:0]            l1_vld_rd_ff;
   logic [P1_W-1:0]               l1_ptr_rd_ff;
   logic [L2_WAYS-1:0][TAG_W-1:0] l2_tag_rd_ff, l2_tag_ff, l2_tag_in;
   logic [L2_WAYS-1:0]            l2_vld_rd_ff, l2_vld_ff, l2_vld_in;
   logic [P2_W-1:0]               l2_ptr_rd_ff, l2_ptr_ff, l2_ptr_in;

   state_type    state_ff;
   logic [CLR_W-1:0] clr_ff;
   tlc_item_type item_ff;
   logic         full1_ff;
   logic [2:0]   st1_ff;
   logic         rsp_valid_ff;
   tlc_rsp_type  rsp_ff;

   logic         pop_fire;
   logic         hit1, free1;
   logic [WAYCNT_W-1:0] fw1, v1, ins1;
   logic [L1_WAYS-1:0][TAG_W-1:0] l1_wtag;
   logic [L1_WAYS-1:0]            l1_wvld;
   logic [P1_W-1:0]               l1_wptr;
   logic         free2;
   logic [WAYCNT_W-1:0] fw2, v2, ins2;
   logic         hit2;
   logic [L2_WAYS-1:0] l2_inv_vld;
   logic         l1_we, l2_we;
   logic [S1_W-1:0] l1_waddr;
   logic [S2_W-1:0] l2_waddr;
   logic [L1_WAYS-1:0][TAG_W-1:0] l1_mtag;
   logic [L1_WAYS-1:0]            l1_mvld;
   logic [P1_W-1:0]               l1_mptr;
   logic [L2_WAYS-1:0][TAG_W-1:0] l2_mtag;
   logic [L2_WAYS-1:0]            l2_mvld;
   logic [P2_W-1:0]               l2_mptr;

   assign pop_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign pop_fire  = pop_valid && pop_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign clearing  = (state_ff == S_CLR);

   // L1: lookup and fill/victim choice on the row just read
   always_comb begin
      hit1 = 1'b0;
      free1 = 1'b0;
      fw1 = '0;
      for (int w = 0; w < L1_WAYS; w++) begin
         if (WAYCNT_W'(w) < item_ff.ways1) begin
            if (l1_vld_rd_ff[w] && l1_tag_rd_ff[w] == item_ff.tag1) hit1 = 1'b1;
            if (!l1_vld_rd_ff[w] && !free1) begin
               free1 = 1'b1;
               fw1 = WAYCNT_W'(w);
            end
         end
      end
      v1 = (WAYCNT_W'(l1_ptr_rd_ff) >= item_ff.ways1) ? '0 : WAYCNT_W'(l1_ptr_rd_ff);
      ins1 = free1 ? fw1 : v1;
      l1_wtag = l1_tag_rd_ff;
      l1_wvld = l1_vld_rd_ff;
      for (int w = 0; w < L1_WAYS; w++) begin
         if (WAYCNT_W'(w) == ins1) begin
            l1_wtag[w] = item_ff.tag1;
            l1_wvld[w] = 1'b1;
         end
      end
      l1_wptr = free1 ? l1_ptr_rd_ff :
                ((v1 + WAYCNT_W'(1) >= item_ff.ways1) ? '0 : P1_W'(v1 + WAYCNT_W'(1)));
   end

   // L2 insert, taken only when the L1 set was full on a read miss
   always_comb begin
      free2 = 1'b0;
      fw2 = '0;
      for (int w = 0; w < L2_WAYS; w++) begin
         if (WAYCNT_W'(w) < item_ff.ways2 && !l2_vld_rd_ff[w] && !free2) begin
            free2 = 1'b1;
            fw2 = WAYCNT_W'(w);
         end
      end
      v2 = (WAYCNT_W'(l2_ptr_rd_ff) >= item_ff.ways2) ? '0 : WAYCNT_W'(l2_ptr_rd_ff);
      ins2 = free2 ? fw2 : v2;
      l2_tag_in = l2_tag_rd_ff;
      l2_vld_in = l2_vld_rd_ff;
      l2_ptr_in = l2_ptr_rd_ff;
      if (!item_ff.is_write && full1_ff) begin
         for (int w = 0; w < L2_WAYS; w++) begin
            if (WAYCNT_W'(w) == ins2) begin
               l2_tag_in[w] = item_ff.tag2;
               l2_vld_in[w] = 1'b1;
            end
         end
         if (!free2) begin
            l2_ptr_in = (v2 + WAYCNT_W'(1) >= item_ff.ways2) ? '0 :
                        P2_W'(v2 + WAYCNT_W'(1));
         end
      end
   end

   // L2 lookup; a read hit drops the first matching way
   always_comb begin
      hit2 = 1'b0;
      l2_inv_vld = l2_vld_ff;
      for (int w = 0; w < L2_WAYS; w++) begin
         if (WAYCNT_W'(w) < item_ff.ways2 && l2_vld_ff[w] &&
             l2_tag_ff[w] == item_ff.tag2 && !hit2) begin
            hit2 = 1'b1;
            l2_inv_vld[w] = 1'b0;
         end
      end
   end

   // memory write ports
   always_comb begin
      l1_we    = 1'b0;
      l2_we    = 1'b0;
      l1_waddr = item_ff.set1[S1_W-1:0];
      l2_waddr = item_ff.set2[S2_W-1:0];
      l1_mtag  = l1_wtag;
      l1_mvld  = l1_wvld;
      l1_mptr  = l1_wptr;
      l2_mtag  = l2_tag_ff;
      l2_mvld  = l2_inv_vld;
      l2_mptr  = l2_ptr_ff;
      if (state_ff == S_CLR) begin
         l1_we    = (32'(clr_ff) < L1_SETS);
         l2_we    = (32'(clr_ff) < L2_SETS);
         l1_waddr = S1_W'(clr_ff);
         l2_waddr = S2_W'(clr_ff);
         l1_mtag  = '0;
         l1_mvld  = '0;
         l1_mptr  = '0;
         l2_mtag  = '0;
         l2_mvld  = '0;
         l2_mptr  = '0;
      end else if (state_ff == S_L1) begin
         l1_we = !hit1 && !item_ff.is_write;
      end else if (state_ff == S_L2B) begin
         l2_we = hit2 && !item_ff.is_write;
      end
   end

   always_ff @(posedge clock) begin
      if (l1_we) begin
         l1_tag_mem[l1_waddr] <= l1_mtag;
         l1_vld_mem[l1_waddr] <= l1_mvld;
         l1_ptr_mem[l1_waddr] <= l1_mptr;
      end
      if (pop_fire) begin
         l1_tag_rd_ff <= l1_tag_mem[pop_data.set1[S1_W-1:0]];
         l1_vld_rd_ff <= l1_vld_mem[pop_data.set1[S1_W-1:0]];
         l1_ptr_rd_ff <= l1_ptr_mem[pop_data.set1[S1_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (l2_we) begin
         l2_tag_mem[l2_waddr] <= l2_mtag;
         l2_vld_mem[l2_waddr] <= l2_mvld;
         l2_ptr_mem[l2_waddr] <= l2_mptr;
      end
      if (pop_fire) begin
         l2_tag_rd_ff <= l2_tag_mem[pop_data.set2[S2_W-1:0]];
         l2_vld_rd_ff <= l2_vld_mem[pop_data.set2[S2_W-1:0]];
         l2_ptr_rd_ff <= l2_ptr_mem[pop_data.set2[S2_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + CLR_W'(1);
               if (32'(clr_ff) == CLR_N - 1) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (pop_fire) begin
                  item_ff  <= pop_data;
                  state_ff <= S_L1;
               end
            end
            S_L1: begin
               if (hit1) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.l1_status   <= item_ff.is_write ? ST_WH : ST_RH;
                  rsp_ff.l2_status   <= ST_NONE;
                  state_ff           <= S_IDLE;
               end else begin
                  st1_ff   <= item_ff.is_write ? ST_WM : ST_RM;
                  full1_ff <= !free1;
                  state_ff <= S_L2;
               end
            end
            S_L2: begin
               l2_tag_ff <= l2_tag_in;
               l2_vld_ff <= l2_vld_in;
               l2_ptr_ff <= l2_ptr_in;
               state_ff  <= S_L2B;
            end
            S_L2B: begin
               rsp_valid_ff     <= 1'b1;
               rsp_ff.l1_status <= st1_ff;
               if (item_ff.is_write) begin
                  rsp_ff.l2_status <= hit2 ? ST_WH : ST_WM;
               end else begin
                  rsp_ff.l2_status <= hit2 ? ST_RH : ST_RM;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

### sv/two_level_cache_hit_miss_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_cache_hit_miss_tracker
// Tag directories of a set-associative L1 and L2; one hit/miss status per
// level for each read or write access.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one access per beat (read/write kind and byte address).
//   rsp_*  : one beat per access, in order, with the L1 and L2 status.
//   csr_*  : register writes, index 0..5 as l1 offset/index/ways and
//            l2 offset/index/ways; always ready, unknown indexes dropped.
//   The front end registers and splits the address, then a two-entry
//   queue feeds the tag sequencer, so requests are still taken while the
//   sequencer or the response side stalls, until front and queue are full.
//   An access passes the front register and the queue, then the set read
//   and the L1 update; an L1 hit responds there, an L1 miss goes on
//   through the L2 insert and the L2 lookup. The tag sequencer takes a
//   new access only when idle and its response register is free or taken;
//   it does one memory step per cycle with registered set reads.
//   Reset: a clearing pass over every set row of both levels wipes
//   valid bits and victim pointers; requests queue up but no access is
//   processed until it ends. Registers return to 6,6,4,6,9,8.
//   A stalled rsp_ready holds the response; up to three more accesses wait.
// ----------------------------------------------------------------------------
module two_level_cache_hit_miss_tracker import tlc_pkg::*; #(
   parameter int L1_SETS   = 64,
   parameter int L1_WAYS   = 4,
   parameter int L2_SETS   = 512,
   parameter int L2_WAYS   = 8,
   parameter int ADDR_BITS = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  tlc_req_type           req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output tlc_rsp_type           rsp_data,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire [CSR_IDX_W-1:0]   csr_index,
   input  wire [CSR_DAT_W-1:0]   csr_wdata
);

   tlc_cfg_type  cfg_ff;
   logic         push_valid, push_ready, pop_valid, pop_ready;
   tlc_item_type push_data, pop_data;
   logic         clearing;

   assign csr_ready = 1'b1;

   // configuration registers; the user must write them only while the block is idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.l1_offset_bits <= 5'd6;
         cfg_ff.l1_index_bits  <= 3'd6;
         cfg_ff.l1_ways_used   <= 3'd4;
         cfg_ff.l2_offset_bits <= 5'd6;
         cfg_ff.l2_index_bits  <= 4'd9;
         cfg_ff.l2_ways_used   <= 4'd8;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_L1_OFF:  cfg_ff.l1_offset_bits <= csr_wdata;
            REG_L1_IDX:  cfg_ff.l1_index_bits  <= csr_wdata[2:0];
            REG_L1_WAYS: cfg_ff.l1_ways_used   <= csr_wdata[2:0];
            REG_L2_OFF:  cfg_ff.l2_offset_bits <= csr_wdata;
            REG_L2_IDX:  cfg_ff.l2_index_bits  <= csr_wdata[3:0];
            REG_L2_WAYS: cfg_ff.l2_ways_used   <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // split address into set and tag per level
   tlc_front #(
      .L1_SETS(L1_SETS), .L1_WAYS(L1_WAYS), .L2_SETS(L2_SETS),
      .L2_WAYS(L2_WAYS), .ADDR_BITS(ADDR_BITS)
   ) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .cfg(cfg_ff),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
   );

   // decouple classification from the tag sequencer
   tlc_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
   );

   // read-modify-write of the tag rows, response register
   tlc_back #(
      .L1_SETS(L1_SETS), .L1_WAYS(L1_WAYS), .L2_SETS(L2_SETS), .L2_WAYS(L2_WAYS)
   ) u_back (
      .clock(clock), .reset(reset),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .clearing(clearing)
   );

   // no access leaves the queue during the clearing pass
   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !(pop_valid && pop_ready))
      else $error("access taken during clearing pass");

   // an L1 hit never reports an L2 status
   a_hit_has_no_l2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.l1_status == ST_RH || rsp_data.l1_status == ST_WH)
      |-> rsp_data.l2_status == ST_NONE)
      else $error("L2 status on an L1 hit");

   // an L1 miss always reports an L2 status of the same kind
   a_miss_has_l2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.l1_status == ST_RM || rsp_data.l1_status == ST_WM)
      |-> (rsp_data.l1_status == ST_RM &&
           (rsp_data.l2_status == ST_RH || rsp_data.l2_status == ST_RM)) ||
          (rsp_data.l1_status == ST_WM &&
           (rsp_data.l2_status == ST_WH || rsp_data.l2_status == ST_WM)))
      else $error("L2 status missing or of the wrong kind on an L1 miss");

endmodule
`default_nettype wire

### verif/two_level_cache_hit_miss_tracker_tb.sv
// ----------------------------------------------------------------------------
// two_level_cache_hit_miss_tracker_tb
// Drives read and write accesses through several cache geometries, predicts
// the L1 and L2 hit/miss status of each access from a local copy of both tag
// directories, and compares every response beat against that prediction.
// ----------------------------------------------------------------------------
module two_level_cache_hit_miss_tracker_tb;
   import tlc_pkg::*;

   localparam int N_L1_SETS = 64;
   localparam int N_L1_WAYS = 4;
   localparam int N_L2_SETS = 512;
   localparam int N_L2_WAYS = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   tlc_req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   tlc_rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   two_level_cache_hit_miss_tracker u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Shadow copy of both tag directories and the register file.
   logic [31:0] l1_tags [N_L1_SETS*N_L1_WAYS];
   logic        l1_vld  [N_L1_SETS*N_L1_WAYS];
   int          l1_rr   [N_L1_SETS];
   logic [31:0] l2_tags [N_L2_SETS*N_L2_WAYS];
   logic        l2_vld  [N_L2_SETS*N_L2_WAYS];
   int          l2_rr   [N_L2_SETS];
   logic [4:0]  regs [6];

   tlc_rsp_type status_q[$];
   int  errors;
   int  sender_idle_pct;
   int  receiver_idle_pct;
   longint cycles;

   // Resolve one level's geometry, saturating index bits and way count.
   task automatic level_geom(input bit second, input logic [31:0] addr,
                             output int set, output logic [31:0] tag,
                             output int ways);
      int off, idx, maxidx, maxw, sh;
      off = second ? regs[3] : regs[0];
      idx = second ? int'(regs[4][3:0]) : int'(regs[1][2:0]);
      ways = second ? int'(regs[5][3:0]) : int'(regs[2][2:0]);
      maxidx = second ? 9 : 6;
      maxw = second ? N_L2_WAYS : N_L1_WAYS;
      if (idx > maxidx) idx = maxidx;
      if (ways < 1) ways = 1;
      if (ways > maxw) ways = maxw;
      sh = off + idx;
      set = int'((64'(addr) >> off) & ((64'd1 << idx) - 64'd1));
      tag = (sh >= 32) ? 32'd0 : (addr >> sh);
   endtask

   function automatic int find_way(bit second, int set, logic [31:0] tag, int ways);
      int b;
      b = second ? set * N_L2_WAYS : set * N_L1_WAYS;
      for (int w = 0; w < ways; w++) begin
         if (second) begin
            if (l2_vld[b+w] && l2_tags[b+w] == tag) return w;
         end else begin
            if (l1_vld[b+w] && l1_tags[b+w] == tag) return w;
         end
      end
      return -1;
   endfunction

   // Fill the first free way, else the round-robin victim; report a full set.
   function automatic bit fill_way(bit second, int set, logic [31:0] tag, int ways);
      int b, v;
      b = second ? set * N_L2_WAYS : set * N_L1_WAYS;
      for (int w = 0; w < ways; w++) begin
         if (second ? !l2_vld[b+w] : !l1_vld[b+w]) begin
            if (second) begin
               l2_vld[b+w] = 1'b1;
               l2_tags[b+w] = tag;
            end else begin
               l1_vld[b+w] = 1'b1;
               l1_tags[b+w] = tag;
            end
            return 1'b0;
         end
      end
      v = second ? l2_rr[set] : l1_rr[set];
      if (v >= ways) v = 0;
      if (second) begin
         l2_tags[b+v] = tag;
         l2_vld[b+v] = 1'b1;
         l2_rr[set] = (v + 1 >= ways) ? 0 : v + 1;
      end else begin
         l1_tags[b+v] = tag;
         l1_vld[b+v] = 1'b1;
         l1_rr[set] = (v + 1 >= ways) ? 0 : v + 1;
      end
      return 1'b1;
   endfunction

   task automatic predict_status(input tlc_req_type acc);
      int s1, s2, w1, w2, hit;
      logic [31:0] t1, t2;
      tlc_rsp_type st;
      level_geom(1'b0, acc.address, s1, t1, w1);
      level_geom(1'b1, acc.address, s2, t2, w2);
      if (find_way(1'b0, s1, t1, w1) >= 0) begin
         st.l1_status = acc.req_type ? ST_WH : ST_RH;
         st.l2_status = ST_NONE;
      end else if (acc.req_type) begin
         st.l1_status = ST_WM;
         st.l2_status = (find_way(1'b1, s2, t2, w2) >= 0) ? ST_WH : ST_WM;
      end else begin
         st.l1_status = ST_RM;
         if (fill_way(1'b0, s1, t1, w1)) void'(fill_way(1'b1, s2, t2, w2));
         hit = find_way(1'b1, s2, t2, w2);
         if (hit >= 0) begin
            // exclusive: the line leaves L2 once it moves up
            l2_vld[s2*N_L2_WAYS + hit] = 1'b0;
            st.l2_status = ST_RH;
         end else begin
            st.l2_status = ST_RM;
         end
      end
      status_q.push_back(st);
   endtask

   // Send one access beat; idle first at the sender's current rate.
   // Valid stays high after the beat until the next idle cycle or wait_idle.
   task automatic send_access(input logic rw, input logic [31:0] addr);
      tlc_req_type acc;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      acc.req_type = rw;
      acc.address = addr;
      req_valid <= 1'b1;
      req_data <= acc;
      do @(posedge clock); while (!req_ready);
      predict_status(acc);
   endtask

   // Write a register only when the block is idle; set_geometry drops valid.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [4:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      regs[idx] = val;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(input logic [4:0] o1, input logic [4:0] i1,
                               input logic [4:0] w1, input logic [4:0] o2,
                               input logic [4:0] i2, input logic [4:0] w2);
      wait_idle();
      write_reg(REG_L1_OFF, o1);
      write_reg(REG_L1_IDX, i1);
      write_reg(REG_L1_WAYS, w1);
      write_reg(REG_L2_OFF, o2);
      write_reg(REG_L2_IDX, i2);
      write_reg(REG_L2_WAYS, w2);
      csr_valid <= 1'b0;
   endtask

   // Addresses drawn from a small pool so sets fill, evict and hit in L2.
   function automatic logic [31:0] pool_addr();
      logic [31:0] a;
      a = 32'({3'($urandom_range(7)), 9'd0, 2'($urandom_range(3)), 8'd0,
               8'($urandom)});
      if ($urandom_range(9) == 0) a = $urandom;
      return a;
   endfunction

   task automatic run_random(input int count);
      logic rw;
      logic [31:0] a;
      for (int i = 0; i < count; i++) begin
         rw = ($urandom_range(3) == 0);
         a = pool_addr();
         send_access(rw, a);
         // re-read the same line often to see the exclusive hand-off
         if (!rw && $urandom_range(3) == 0) send_access(1'b0, a);
      end
   endtask

   task automatic test_directed();
      send_access(1'b0, 32'h0000_0000);
      send_access(1'b0, 32'h0000_0000);
      send_access(1'b1, 32'h0000_0000);
      send_access(1'b1, 32'hFFFF_FFFF);
      send_access(1'b0, 32'hFFFF_FFFF);
      send_access(1'b0, 32'hAAAA_AAAA);
      send_access(1'b0, 32'h5555_5555);
      // overflow one L1 set so read misses find it full and take the L2 insert path, then access the first line again
      for (int k = 0; k < 6; k++) send_access(1'b0, 32'h1000 * k);
      send_access(1'b1, 32'h0000_0000);
      send_access(1'b0, 32'h0000_0000);
      send_access(1'b0, 32'h0000_0000);
   endtask

   task automatic test_tiny_geometry();
      // one way, no index bits: once the way is filled, every read miss evicts and inserts into L2
      set_geometry(5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
      run_random(60);
   endtask

   task automatic test_saturated_geometry();
      // index and way counts beyond the array sizes, offsets that eat the tag
      set_geometry(5'd31, 5'd7, 5'd7, 5'd16, 5'd15, 5'd15);
      run_random(40);
      set_geometry(5'd16, 5'd6, 5'd4, 5'd16, 5'd9, 5'd8);
      run_random(40);
   endtask

   task automatic test_shrunk_ways();
      // fewer ways than before leaves victim pointers past the end
      set_geometry(5'd4, 5'd2, 5'd4, 5'd4, 5'd3, 5'd8);
      run_random(100);
      set_geometry(5'd4, 5'd2, 5'd2, 5'd4, 5'd3, 5'd3);
      run_random(100);
   endtask

   task automatic test_random_mix();
      set_geometry(5'd6, 5'd6, 5'd4, 5'd6, 5'd9, 5'd8);
      sender_idle_pct = 25; receiver_idle_pct = 49;
      run_random(100);
      set_geometry(5'd2, 5'd3, 5'd3, 5'd3, 5'd4, 5'd5);
      sender_idle_pct = 49; receiver_idle_pct = 25;
      run_random(100);
      sender_idle_pct = 0; receiver_idle_pct = 0;
      run_random(100);
   endtask

   // Drive rsp_ready and compare each response beat with the oldest prediction.
   always @(posedge clock) begin
      tlc_rsp_type exp_st;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) begin
               $error("unexpected response beat l1_status=%0d l2_status=%0d",
                      rsp_data.l1_status, rsp_data.l2_status);
               errors++;
            end else begin
               exp_st = status_q.pop_front();
               if (rsp_data.l1_status !== exp_st.l1_status) begin
                  $error("l1_status expected %0d actual %0d",
                         exp_st.l1_status, rsp_data.l1_status);
                  errors++;
               end
               if (rsp_data.l2_status !== exp_st.l2_status) begin
                  $error("l2_status expected %0d actual %0d",
                         exp_st.l2_status, rsp_data.l2_status);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Hold a hard limit on the run length.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      errors = 0;
      cycles = 0;
      sender_idle_pct = 25;
      receiver_idle_pct = 49;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      regs[0] = 5'd6; regs[1] = 5'd6; regs[2] = 5'd4;
      regs[3] = 5'd6; regs[4] = 5'd9; regs[5] = 5'd8;
      for (int i = 0; i < N_L1_SETS*N_L1_WAYS; i++) l1_vld[i] = 1'b0;
      for (int i = 0; i < N_L1_SETS; i++) l1_rr[i] = 0;
      for (int i = 0; i < N_L2_SETS*N_L2_WAYS; i++) l2_vld[i] = 1'b0;
      for (int i = 0; i < N_L2_SETS; i++) l2_rr[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_tiny_geometry();
      test_saturated_geometry();
      test_shrunk_ways();
      test_random_mix();
      wait_idle();
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
